>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; the list engine includes them.
// Each check is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

    // Fixed field widths of the request and response transfers.
    localparam int OP_W    = 2;
    localparam int POS_W   = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // Default sizing of the list.
    localparam int DEPTH_DEF         = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } ple_op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } ple_status_t;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
    } ple_cmd_t;

    // Readout selection broadcast to every cell of the row.
    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
        logic             nonempty;
        logic [POS_W-1:0] last_idx;
    } ple_sel_t;

endpackage

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
`default_nettype none
`include "assert_macros.svh"

// Channel  | Dir | Handshake             | Fields
// ---------+-----+-----------------------+---------------------------------------------------
// request  | in  | req_valid / req_stall | op, position, element
// response | out | rsp_valid / rsp_stall | status, read_value, count, first_value, last_value
//
// Every accepted request gives exactly one response transfer, from the output register.
// One request can be accepted in every cycle: the cell row shifts in the cycle of acceptance,
// and a result stage reads the row in the following cycle while the next request shifts it.
// Reset clears the fill count and the pipeline valid flags; the stored words are not cleared.
// A stalled response holds the result stage, which in turn stalls the request channel.

module positional_list_engine #(
    parameter int DEPTH         = ple_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = ple_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [ple_pkg::OP_W-1:0]      op,
    input  wire logic [ple_pkg::POS_W-1:0]     position,
    input  wire logic [ple_pkg::DATA_W-1:0]    element,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [1:0]                    status,
    output logic      [ple_pkg::DATA_W-1:0]    read_value,
    output logic      [ple_pkg::COUNT_W-1:0]   count,
    output logic      [ple_pkg::DATA_W-1:0]    first_value,
    output logic      [ple_pkg::DATA_W-1:0]    last_value
);
    import ple_pkg::*;

    // Width of the fill count, which must be able to hold DEPTH itself.
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Fill count of the cell row.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Result stage: holds one transfer whose readout happens in this cycle.
    logic              p_valid_reg;
    logic              p_valid_next;
    ple_status_t       p_status_reg;
    ple_status_t       p_status_next;
    logic [CW-1:0]     p_count_reg;
    logic              p_rd_en_reg;
    logic              p_rd_en_next;
    logic [POS_W-1:0]  p_rd_pos_reg;

    // Output register.
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    ple_status_t       rsp_status_reg;
    logic [DATA_W-1:0] rsp_read_reg;
    logic [COUNT_W-1:0] rsp_count_reg;
    logic [DATA_W-1:0] rsp_first_reg;
    logic [DATA_W-1:0] rsp_last_reg;

    logic              req_accept;
    logic              grow_accept;
    logic              out_load;
    logic [POS_W-1:0]  cnt_pos;
    logic [POS_W-1:0]  eff_pos;
    ple_cmd_t          cmd;
    ple_sel_t          sel;

    logic [ELEMENT_WIDTH-1:0] word;
    logic [ELEMENT_WIDTH-1:0] cell_val  [DEPTH];
    logic [ELEMENT_WIDTH-1:0] rd_part   [DEPTH];
    logic [ELEMENT_WIDTH-1:0] last_part [DEPTH];
    logic [ELEMENT_WIDTH-1:0] rd_word;
    logic [ELEMENT_WIDTH-1:0] last_word;
    logic [ELEMENT_WIDTH-1:0] first_word;

    // ------------------------------------------------------------------
    // Handshake. The result stage moves to the output register whenever
    // that register is empty or its transfer completes in this cycle.
    // ------------------------------------------------------------------
    assign out_load   = p_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = p_valid_reg && !out_load;
    assign req_accept = req_valid && !req_stall;

    // An accepted insert that finds room in the list.
    assign grow_accept = req_accept && (op == OP_INSERT) && (count_reg != FULL_COUNT);

    assign word    = ELEMENT_WIDTH'(element);
    assign cnt_pos = POS_W'(count_reg);

    // ------------------------------------------------------------------
    // Operation decode. Insert and delete positions past the end of
    // the list are clamped to its end before being broadcast to the cells.
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd           = '0;
        eff_pos       = position;
        count_next    = count_reg;
        p_status_next = ST_OK;
        p_rd_en_next  = 1'b0;
        unique case (ple_op_t'(op))
            OP_INSERT:
            begin
                if (position > cnt_pos)
                    eff_pos = cnt_pos;
                if (count_reg == FULL_COUNT)
                    p_status_next = ST_FULL;
                else
                begin
                    cmd.ins    = req_accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (position >= cnt_pos)
                    eff_pos = cnt_pos - 1'b1;
                if (count_reg == '0)
                    p_status_next = ST_EMPTY;
                else
                begin
                    cmd.del    = req_accept;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (position < cnt_pos)
                    p_rd_en_next = 1'b1;
                else
                    p_status_next = ST_ABSENT;
            end
            default:
            begin
                // The unused code leaves the list alone and reports success.
                p_status_next = ST_OK;
            end
        endcase
        cmd.pos = eff_pos;
    end

    // ------------------------------------------------------------------
    // Cell row. Cell zero has no lower neighbor and the top cell has no
    // upper neighbor; both are fed zero.
    // ------------------------------------------------------------------
    assign sel.rd_en    = p_rd_en_reg;
    assign sel.rd_pos   = p_rd_pos_reg;
    assign sel.nonempty = (p_count_reg != '0);
    assign sel.last_idx = POS_W'(p_count_reg) - 1'b1;

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] lower_val;
        logic [ELEMENT_WIDTH-1:0] upper_val;

        if (gi == 0)
        begin : g_bottom
            assign lower_val = '0;
        end
        else
        begin : g_lower
            assign lower_val = cell_val[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_top
            assign upper_val = '0;
        end
        else
        begin : g_upper
            assign upper_val = cell_val[gi+1];
        end

        ple_cell #(
            .INDEX         (gi),
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .sel       (sel),
            .word      (word),
            .lower_val (lower_val),
            .upper_val (upper_val),
            .val       (cell_val[gi]),
            .rd_part   (rd_part[gi]),
            .last_part (last_part[gi])
        );
    end

    // At most one cell drives a nonzero part for each readout, so the
    // selection is an OR over the row.
    always_comb
    begin
        rd_word   = '0;
        last_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word   = rd_word | rd_part[i];
            last_word = last_word | last_part[i];
        end
    end

    assign first_word = sel.nonempty ? cell_val[0] : '0;

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (req_accept)
            p_valid_next = 1'b1;
        else if (out_load)
            p_valid_next = 1'b0;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
                count_reg <= count_next;
            p_valid_reg   <= p_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers of the result stage and the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            p_status_reg <= p_status_next;
            p_count_reg  <= count_next;
            p_rd_en_reg  <= p_rd_en_next;
            p_rd_pos_reg <= position;
        end
        if (out_load)
        begin
            rsp_status_reg <= p_status_reg;
            rsp_read_reg   <= DATA_W'(rd_word);
            rsp_count_reg  <= COUNT_W'(p_count_reg);
            rsp_first_reg  <= DATA_W'(first_word);
            rsp_last_reg   <= DATA_W'(last_word);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign read_value  = rsp_read_reg;
    assign count       = rsp_count_reg;
    assign first_value = rsp_first_reg;
    assign last_value  = rsp_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT)
    `ASSERT_SAME(a_stage_blocks_req, clk, rst_n, p_valid_reg && !out_load, req_stall)
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, grow_accept, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_NEXT(a_shift_has_stage, clk, rst_n, req_accept, p_valid_reg)

endmodule

`default_nettype wire

>>> hw/rtl/ple_cell.sv
`default_nettype none

module ple_cell #(
    parameter int INDEX         = 0,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire ple_pkg::ple_cmd_t        cmd,
    input  wire ple_pkg::ple_sel_t        sel,
    input  wire logic [ELEMENT_WIDTH-1:0] word,
    input  wire logic [ELEMENT_WIDTH-1:0] lower_val,
    input  wire logic [ELEMENT_WIDTH-1:0] upper_val,
    output logic      [ELEMENT_WIDTH-1:0] val,
    output logic      [ELEMENT_WIDTH-1:0] rd_part,
    output logic      [ELEMENT_WIDTH-1:0] last_part
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [ELEMENT_WIDTH-1:0] val_next;

    // Insert opens a slot at the position by taking the lower neighbor's word;
    // delete closes it by taking the upper neighbor's word.
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > cmd.pos)
                val_next = lower_val;
            else if (MY_IDX == cmd.pos)
                val_next = word;
        end
        else if (cmd.del)
        begin
            if (MY_IDX >= cmd.pos)
                val_next = upper_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val       = val_reg;
    assign rd_part   = (sel.rd_en && (MY_IDX == sel.rd_pos)) ? val_reg : '0;
    assign last_part = (sel.nonempty && (MY_IDX == sel.last_idx)) ? val_reg : '0;

endmodule

`default_nettype wire

>>> dv/ple_checker.sv
`default_nettype none

// Watches both channels of the positional list engine, keeps its own copy of
// the list and compares every response transfer against the oldest prediction.
module ple_checker
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_stall,
    input  wire logic [OP_W-1:0]    op,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic [DATA_W-1:0]  element,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_stall,
    input  wire logic [1:0]         status,
    input  wire logic [DATA_W-1:0]  read_value,
    input  wire logic [COUNT_W-1:0] count,
    input  wire logic [DATA_W-1:0]  first_value,
    input  wire logic [DATA_W-1:0]  last_value,
    output int                      pending,
    output int                      mismatches,
    output int                      checked,
    output int                      full_hits,
    output int                      empty_hits
);

    typedef struct packed {
        logic [1:0]         status;
        logic [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  first_value;
        logic [DATA_W-1:0]  last_value;
    } list_result_t;

    logic [DATA_W-1:0] words [DEPTH];
    int                held;
    list_result_t      awaited [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Applies one operation to the shadow list and returns the response it implies.
    task automatic apply_list_op(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] word, output list_result_t res);
        int slot;
        res = '0;
        res.status = ST_OK;
        case (code)
            OP_INSERT:
            begin
                if (held >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    slot = (int'(pos) > held) ? held : int'(pos);
                    for (int i = held; i > slot; i--)
                        words[i] = words[i-1];
                    words[slot] = word;
                    held++;
                end
            end
            OP_DELETE:
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    slot = (int'(pos) >= held) ? held - 1 : int'(pos);
                    for (int i = slot; i + 1 < held; i++)
                        words[i] = words[i+1];
                    held--;
                end
            end
            OP_READ:
            begin
                if (int'(pos) < held)
                    res.read_value = words[pos];
                else
                    res.status = ST_ABSENT;
            end
            default:
            begin
            end
        endcase
        res.count = COUNT_W'(held);
        if (held != 0)
        begin
            res.first_value = words[0];
            res.last_value  = words[held-1];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t predicted;
        list_result_t oldest;
        if (!rst_n)
        begin
            held = 0;
            awaited.delete();
            pending <= 0;
            mismatches = 0;
            checked = 0;
            full_hits = 0;
            empty_hits = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                apply_list_op(op, position, element, predicted);
                awaited.push_back(predicted);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited.size() == 0)
                begin
                    report_mismatch("response transfer with no request outstanding");
                end
                else
                begin
                    oldest = awaited.pop_front();
                    checked++;
                    if (oldest.status == ST_FULL)
                        full_hits++;
                    if (oldest.status == ST_EMPTY)
                        empty_hits++;
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, oldest.status));
                    if (read_value !== oldest.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  read_value, oldest.read_value));
                    if (count !== oldest.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  count, oldest.count));
                    if (first_value !== oldest.first_value)
                        report_mismatch($sformatf("first_value %h, expected %h",
                                                  first_value, oldest.first_value));
                    if (last_value !== oldest.last_value)
                        report_mismatch($sformatf("last_value %h, expected %h",
                                                  last_value, oldest.last_value));
                end
            end
            pending <= awaited.size();
        end
    end

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

// Top of the list engine bench. It makes the request stimulus and the response
// back-pressure, and gives the verdict; all prediction and comparison lives in
// the checker instance that sits beside the engine.
module tb;
    import ple_pkg::*;

    // The package names only the three defined operations; the fourth code
    // must leave the list alone, so it gets a name of its own here.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1625;
    localparam int MAX_IDLE     = 18;
    // A response passes the engine's result stage and output register, so a
    // drain of DRAIN_CYCLES is enough to catch a stray transfer at the end.
    localparam int DRAIN_CYCLES = 8;
    // The limit is several times the slowest correct run, in which both sides
    // idle their longest on every item on top of the pipeline.
    localparam int CYCLE_LIMIT  = 400000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   position;
    logic [DATA_W-1:0]  element;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [1:0]         status;
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  first_value;
    logic [DATA_W-1:0]  last_value;

    int pending;
    int mismatches;
    int checked;
    int full_hits;
    int empty_hits;

    int cycles;
    int inserts_sent;
    int deletes_sent;
    int reads_sent;
    int unused_sent;
    bit req_quiet;
    bit rsp_quiet;

    positional_list_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .position    (position),
        .element     (element),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .read_value  (read_value),
        .count       (count),
        .first_value (first_value),
        .last_value  (last_value)
    );

    ple_checker watcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .position    (position),
        .element     (element),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .read_value  (read_value),
        .count       (count),
        .first_value (first_value),
        .last_value  (last_value),
        .pending     (pending),
        .mismatches  (mismatches),
        .checked     (checked),
        .full_hits   (full_hits),
        .empty_hits  (empty_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: if the run has not ended by the limit, something has hung.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d responses outstanding", cycles, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Issues one request transfer. The idle gap comes first, and valid is
    // only lowered when there really is a gap, so back-to-back transfers keep
    // valid high without a second assignment in the same step. The call
    // returns at the edge where the transfer was accepted.
    task automatic send_request(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] word);
        int gap;
        gap = req_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= code;
        position  <= pos;
        element   <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        case (code)
            OP_INSERT: inserts_sent++;
            OP_DELETE: deletes_sent++;
            OP_READ:   reads_sent++;
            default:   unused_sent++;
        endcase
    endtask

    // Picks a position: half the time up to just past the list depth so inserts
    // and deletes land in the middle of the list, sometimes anywhere, sometimes the ends.
    function automatic logic [POS_W-1:0] pick_position();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return POS_W'($urandom_range(0, DEPTH_DEF + 1));
        if (sel < 8)
            return POS_W'($urandom_range(0, 255));
        if (sel == 8)
            return '0;
        return '1;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return DATA_W'($urandom);
    endfunction

    // Response side: before each response transfer it holds stall for a
    // random number of cycles, then lowers it and waits for the transfer.
    // Some stretches of 40 responses take no back-pressure at all.
    initial
    begin : response_side
        int hold;
        int served;
        rsp_stall <= 1'b0;
        rsp_quiet = 1'b0;
        served = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (served % 40 == 0)
                rsp_quiet = ($urandom_range(0, 3) == 0);
            hold = rsp_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            served++;
        end
    end

    initial
    begin : request_side
        int trend;
        int pick;
        logic [OP_W-1:0] code;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        op        <= OP_READ;
        position  <= '0;
        element   <= '0;
        req_quiet = 1'b0;
        inserts_sent = 0;
        deletes_sent = 0;
        reads_sent = 0;
        unused_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty list first: a read finds nothing, a delete
        // reports the list empty, and the unused code changes nothing.
        send_request(OP_READ, 8'd0, '0);
        send_request(OP_DELETE, 8'd0, DATA_W'($urandom));
        send_request(OP_UNUSED, 8'd5, DATA_W'($urandom));

        // Fill to capacity, starting with the extreme words: an insert at
        // the front, one far past the end that must append, then a mix.
        send_request(OP_INSERT, 8'd0, '1);
        send_request(OP_INSERT, 8'd255, '0);
        for (int k = 2; k < DEPTH_DEF; k++)
            send_request(OP_INSERT, POS_W'($urandom_range(0, k + 1)), pick_word());

        // Full list: the insert is refused. Then reads at the last slot,
        // just past it, and a delete far past the end removes the last word.
        send_request(OP_INSERT, 8'd3, DATA_W'($urandom));
        send_request(OP_READ, 8'(DEPTH_DEF - 1), '0);
        send_request(OP_READ, 8'(DEPTH_DEF), '0);
        send_request(OP_DELETE, 8'd255, '0);
        send_request(OP_DELETE, 8'd0, '0);
        send_request(OP_DELETE, 8'd7, '0);

        // Random part. Every 50 items a new trend is chosen that leans
        // toward filling, draining or holding the list level, so the list
        // keeps hitting both full and empty with random content in between.
        trend = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                trend = $urandom_range(0, 2);
                req_quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            case (trend)
                0:       code = (pick < 60) ? OP_INSERT : (pick < 80) ? OP_DELETE : OP_READ;
                1:       code = (pick < 20) ? OP_INSERT : (pick < 65) ? OP_DELETE : OP_READ;
                default: code = (pick < 35) ? OP_INSERT : (pick < 70) ? OP_DELETE : OP_READ;
            endcase
            send_request(code, pick_position(), pick_word());
        end
        req_valid <= 1'b0;

        // Wait for every outstanding response, then a little longer so any
        // extra transfer from the engine is caught by the checker.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests sent: %0d inserts, %0d deletes, %0d reads, %0d with the unused code.",
                 inserts_sent, deletes_sent, reads_sent, unused_sent);
        $display("Responses compared: %0d; refused as full %0d times, as empty %0d times.",
                 checked, full_hits, empty_hits);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine.sv
dv/ple_checker.sv
dv/tb.sv
